>>> design/sse_pkg.sv
// Shared types and constants for the spiral sequence to edges block.
// No dependencies; sse_if, sse_ctrl, sse_datapath and the top level use this package.
package sse_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int MAX_DEGREE_DEF = 15;

  localparam int DEGREE_W = 4;
  localparam int SHIFT_W  = 10;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 3;
  localparam int OPEN_W   = 4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OPEN_COUNT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VALENCY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RING       = 3'd4;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [OP_W-1:0] OP_START      = 5'd2;
  localparam logic [OP_W-1:0] OP_STATUS     = 5'd3;
  localparam logic [OP_W-1:0] OP_ERR_HOLD   = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_HEAD    = 5'd5;
  localparam logic [OP_W-1:0] OP_RD_BACK    = 5'd6;
  localparam logic [OP_W-1:0] OP_RD_IDX     = 5'd7;
  localparam logic [OP_W-1:0] OP_EMIT       = 5'd8;
  localparam logic [OP_W-1:0] OP_MOD_INIT   = 5'd9;
  localparam logic [OP_W-1:0] OP_MOD_STEP   = 5'd10;
  localparam logic [OP_W-1:0] OP_ROT_WR     = 5'd11;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 5'd12;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 5'd13;
  localparam logic [OP_W-1:0] OP_PUSH       = 5'd14;
  localparam logic [OP_W-1:0] OP_I_CLR      = 5'd15;
  localparam logic [OP_W-1:0] OP_I_INC      = 5'd16;
  localparam logic [OP_W-1:0] OP_FINAL_DONE = 5'd17;
  localparam logic [OP_W-1:0] OP_FINISH     = 5'd18;
  localparam logic [OP_W-1:0] OP_OUT_NEXT   = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic err_nz;
    logic nc_zero;
    logic nc_one;
    logic nc_ge_max;
    logic cnt_zero;
    logic cnt_full;
    logic cnt_eq_deg;
    logic used_ge_deg;
    logic open_zero;
    logic open_one;
    logic i_eq_cnt;
    logic rot_zero;
    logic mod_done;
    logic out_last;
  } stat_t;

endpackage

>>> design/sse_if.sv
// Handshake channels for node items and edge results.
// Depends on sse_pkg for field widths.
interface sse_item_if;
  logic                         valid;
  logic                         ready;
  logic [sse_pkg::DEGREE_W-1:0] degree;
  logic [sse_pkg::SHIFT_W-1:0]  jump_shift;
  logic                         first_node;
  logic                         final_node;
  modport source(output valid, degree, jump_shift, first_node, final_node, input ready);
  modport sink(input valid, degree, jump_shift, first_node, final_node, output ready);
endinterface

interface sse_edge_if;
  logic                         valid;
  logic                         ready;
  logic                         edge_valid;
  logic [sse_pkg::IDX_W-1:0]    new_end;
  logic [sse_pkg::IDX_W-1:0]    old_end;
  logic [sse_pkg::STATUS_W-1:0] status;
  logic                         run_last;
  modport source(output valid, edge_valid, new_end, old_end, status, run_last, input ready);
  modport sink(input valid, edge_valid, new_end, old_end, status, run_last, output ready);
endinterface

>>> design/sse_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sse_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> design/sse_ctrl.sv
// Controller state machine: sequences datapath commands per node item.
// Depends on sse_pkg.
module sse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  sse_pkg::stat_t st,
  output sse_pkg::cmd_t  cmd
);
  import sse_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECIDE = 5'd1;
  localparam logic [4:0] S_MOD    = 5'd2;
  localparam logic [4:0] S_ROT    = 5'd3;
  localparam logic [4:0] S_ROT_WR = 5'd4;
  localparam logic [4:0] S_CB_RD  = 5'd5;
  localparam logic [4:0] S_CB_WR  = 5'd6;
  localparam logic [4:0] S_CF_RD  = 5'd7;
  localparam logic [4:0] S_CF_WR  = 5'd8;
  localparam logic [4:0] S_PF_RD  = 5'd9;
  localparam logic [4:0] S_PF_CHK = 5'd10;
  localparam logic [4:0] S_PB_RD  = 5'd11;
  localparam logic [4:0] S_PB_CHK = 5'd12;
  localparam logic [4:0] S_PBC_RD = 5'd13;
  localparam logic [4:0] S_PBC_WR = 5'd14;
  localparam logic [4:0] S_PUSH   = 5'd15;
  localparam logic [4:0] S_S2_WR  = 5'd16;
  localparam logic [4:0] S_FC_RD  = 5'd17;
  localparam logic [4:0] S_FC_T   = 5'd18;
  localparam logic [4:0] S_FE_RD  = 5'd19;
  localparam logic [4:0] S_FE_WR  = 5'd20;
  localparam logic [4:0] S_FINISH = 5'd21;
  localparam logic [4:0] S_OUT    = 5'd22;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_FINISH;
        if (st.first) begin
          cmd.op = OP_START;
        end else if (st.err_nz) begin
          cmd.op = OP_ERR_HOLD;
        end else if (st.nc_zero || st.nc_ge_max) begin
          cmd.op   = OP_STATUS;
          cmd.code = ST_RING;
        end else if (st.nc_one) begin
          if (st.cnt_zero) begin
            cmd.op   = OP_STATUS;
            cmd.code = ST_RING;
          end else begin
            cmd.op     = OP_RD_BACK;
            state_next = S_S2_WR;
          end
        end else if (st.last) begin
          if (!st.cnt_eq_deg) begin
            cmd.op   = OP_STATUS;
            cmd.code = ST_OPEN_COUNT;
          end else begin
            state_next = S_FC_RD;
          end
        end else if (st.cnt_zero) begin
          state_next = S_CB_RD;
        end else begin
          cmd.op     = OP_MOD_INIT;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (st.mod_done) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (st.rot_zero) begin
          state_next = S_CB_RD;
        end else begin
          cmd.op     = OP_RD_HEAD;
          state_next = S_ROT_WR;
        end
      end
      S_ROT_WR: begin
        cmd.op     = OP_ROT_WR;
        state_next = S_ROT;
      end
      S_CB_RD, S_CF_RD, S_PBC_RD: begin
        if (st.cnt_zero) begin
          cmd.op     = OP_STATUS;
          cmd.code   = ST_RING;
          state_next = S_FINISH;
        end else if (st.used_ge_deg) begin
          cmd.op     = OP_STATUS;
          cmd.code   = ST_SATURATED;
          state_next = S_FINISH;
        end else if (state == S_CF_RD) begin
          cmd.op     = OP_RD_HEAD;
          state_next = S_CF_WR;
        end else begin
          cmd.op     = OP_RD_BACK;
          state_next = (state == S_CB_RD) ? S_CB_WR : S_PBC_WR;
        end
      end
      S_CB_WR: begin
        cmd.op     = OP_EMIT;
        state_next = S_CF_RD;
      end
      S_CF_WR: begin
        cmd.op     = OP_EMIT;
        state_next = S_PF_RD;
      end
      S_PBC_WR: begin
        cmd.op     = OP_EMIT;
        state_next = S_PB_RD;
      end
      S_PF_RD: begin
        cmd.op     = OP_RD_HEAD;
        state_next = S_PF_CHK;
      end
      S_PF_CHK: begin
        if (st.open_zero) begin
          cmd.op     = OP_POP_FRONT;
          state_next = S_CF_RD;
        end else begin
          state_next = S_PB_RD;
        end
      end
      S_PB_RD: begin
        cmd.op     = OP_RD_BACK;
        state_next = S_PB_CHK;
      end
      S_PB_CHK: begin
        if (st.open_zero) begin
          cmd.op     = OP_POP_BACK;
          state_next = S_PBC_RD;
        end else if (st.used_ge_deg) begin
          cmd.op     = OP_STATUS;
          cmd.code   = ST_SATURATED;
          state_next = S_FINISH;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_S2_WR: begin
        cmd.op     = OP_EMIT;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        state_next = S_FINISH;
        if (st.cnt_full) begin
          cmd.op   = OP_STATUS;
          cmd.code = ST_RING;
        end else begin
          cmd.op = OP_PUSH;
        end
      end
      S_FC_RD: begin
        if (st.i_eq_cnt) begin
          cmd.op     = OP_I_CLR;
          state_next = S_FE_RD;
        end else begin
          cmd.op     = OP_RD_IDX;
          state_next = S_FC_T;
        end
      end
      S_FC_T: begin
        if (!st.open_one) begin
          cmd.op     = OP_STATUS;
          cmd.code   = ST_VALENCY;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_I_INC;
          state_next = S_FC_RD;
        end
      end
      S_FE_RD: begin
        if (st.i_eq_cnt) begin
          cmd.op     = OP_FINAL_DONE;
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_RD_IDX;
          state_next = S_FE_WR;
        end
      end
      S_FE_WR: begin
        cmd.op     = OP_EMIT;
        state_next = S_FE_RD;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.op = OP_OUT_NEXT;
          if (st.out_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

>>> design/sse_datapath.sv
// Datapath: ring store, ring pointers, modulo unit, edge buffer, result fields.
// Depends on sse_pkg and sse_ram.
module sse_datapath #(
  parameter int MAX_NODES  = sse_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = sse_pkg::MAX_DEGREE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sse_pkg::cmd_t                cmd,
  output sse_pkg::stat_t               st,
  input  logic [sse_pkg::DEGREE_W-1:0] degree,
  input  logic [sse_pkg::SHIFT_W-1:0]  jump_shift,
  input  logic                         first_node,
  input  logic                         final_node,
  output logic                         edge_valid,
  output logic [sse_pkg::IDX_W-1:0]    new_end,
  output logic [sse_pkg::IDX_W-1:0]    old_end,
  output logic [sse_pkg::STATUS_W-1:0] status,
  output logic                         run_last
);
  import sse_pkg::*;

  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int EW   = NW + OPEN_W;
  localparam int EBD  = MAX_DEGREE + 1;
  localparam int EBW  = $clog2(EBD);
  localparam int ENW  = $clog2(EBD + 1);
  localparam int BITW = $clog2(SHIFT_W);

  function automatic logic [NW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= (CW+1)'(MAX_NODES)) ? s - (CW+1)'(MAX_NODES) : s;
    return t[NW-1:0];
  endfunction

  logic [NW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       node_count;
  logic [STATUS_W-1:0] err;
  logic [STATUS_W-1:0] status_r;
  logic [DEGREE_W-1:0] deg;
  logic [SHIFT_W-1:0]  shift;
  logic                first;
  logic                last;
  logic [CW-1:0]       cur_node;
  logic [DEGREE_W-1:0] used;
  logic [IDX_W-1:0]    edge_buf [EBD];
  logic [ENW-1:0]      edge_n;
  logic [NW-1:0]       addr_q;
  logic [CW-1:0]       idx_i;
  logic [CW-1:0]       rem;
  logic [BITW-1:0]     bitc;
  logic [CW-1:0]       rot;
  logic [EBW-1:0]      out_idx;

  logic [NW-1:0]   tail, back, idx_pos, head_inc;
  logic [CW+1:0]   mod_t;
  logic [CW-1:0]   rem_next;
  logic            rd_en, wr_en;
  logic [NW-1:0]   rd_addr, wr_addr;
  logic [EW-1:0]   wr_data, rd_data;
  logic [OPEN_W-1:0] rd_open;
  logic [NW-1:0]   rd_node;
  logic [DEGREE_W-1:0] deg_sat;

  assign tail     = wrap((CW+1)'(head) + (CW+1)'(count));
  assign back     = wrap((CW+1)'(head) + (CW+1)'(count) - (CW+1)'(1));
  assign idx_pos  = wrap((CW+1)'(head) + (CW+1)'(idx_i));
  assign head_inc = wrap((CW+1)'(head) + (CW+1)'(1));
  assign rd_open  = rd_data[OPEN_W-1:0];
  assign rd_node  = rd_data[EW-1:OPEN_W];
  assign deg_sat  = (degree > DEGREE_W'(MAX_DEGREE)) ? DEGREE_W'(MAX_DEGREE) : degree;

  assign mod_t    = {1'b0, rem, shift[bitc]};
  assign rem_next = (mod_t >= (CW+2)'(count)) ? CW'(mod_t - (CW+2)'(count)) : CW'(mod_t);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = {rd_node, rd_open - OPEN_W'(1)};
    case (cmd.op)
      OP_RD_HEAD: rd_en = 1'b1;
      OP_RD_BACK: begin
        rd_en   = 1'b1;
        rd_addr = back;
      end
      OP_RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_pos;
      end
      OP_EMIT: wr_en = 1'b1;
      OP_ROT_WR: begin
        wr_en   = 1'b1;
        wr_addr = tail;
        wr_data = rd_data;
      end
      OP_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = tail;
        wr_data = {NW'(cur_node), OPEN_W'(deg - used)};
      end
      OP_START: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {NW'(0), OPEN_W'(deg)};
      end
      default: ;
    endcase
  end

  sse_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_NODES)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      node_count <= '0;
      err        <= ST_OK;
      edge_n     <= '0;
      out_idx    <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          deg      <= deg_sat;
          shift    <= jump_shift;
          first    <= first_node;
          last     <= final_node;
          used     <= '0;
          status_r <= ST_OK;
          edge_n   <= '0;
          idx_i    <= '0;
          cur_node <= node_count;
        end
        OP_START: begin
          head       <= '0;
          count      <= CW'(1);
          node_count <= CW'(1);
          err        <= ST_OK;
          cur_node   <= '0;
        end
        OP_STATUS:   status_r <= cmd.code;
        OP_ERR_HOLD: status_r <= err;
        OP_RD_HEAD:  addr_q <= head;
        OP_RD_BACK:  addr_q <= back;
        OP_RD_IDX:   addr_q <= idx_pos;
        OP_EMIT: begin
          if (edge_n < ENW'(EBD)) begin
            edge_buf[edge_n[EBW-1:0]] <= IDX_W'(rd_node);
            edge_n <= edge_n + ENW'(1);
          end
          used  <= used + DEGREE_W'(1);
          idx_i <= idx_i + CW'(1);
        end
        OP_MOD_INIT: begin
          rem  <= '0;
          bitc <= BITW'(SHIFT_W - 1);
        end
        OP_MOD_STEP: begin
          rem  <= rem_next;
          rot  <= rem_next;
          bitc <= bitc - BITW'(1);
        end
        OP_ROT_WR: begin
          head <= head_inc;
          rot  <= rot - CW'(1);
        end
        OP_POP_FRONT: begin
          head  <= head_inc;
          count <= count - CW'(1);
        end
        OP_POP_BACK: count <= count - CW'(1);
        OP_PUSH: begin
          count      <= count + CW'(1);
          node_count <= node_count + CW'(1);
        end
        OP_I_CLR: idx_i <= '0;
        OP_I_INC: idx_i <= idx_i + CW'(1);
        OP_FINAL_DONE: begin
          count      <= '0;
          head       <= '0;
          node_count <= node_count + CW'(1);
        end
        OP_FINISH: begin
          if (status_r != ST_OK && err == ST_OK) begin
            err <= status_r;
          end
          out_idx <= '0;
        end
        OP_OUT_NEXT: out_idx <= out_idx + EBW'(1);
        default: ;
      endcase
    end
  end

  assign st.first       = first;
  assign st.last        = last;
  assign st.err_nz      = (err != ST_OK);
  assign st.nc_zero     = (node_count == '0);
  assign st.nc_one      = (node_count == CW'(1));
  assign st.nc_ge_max   = (node_count >= CW'(MAX_NODES));
  assign st.cnt_zero    = (count == '0);
  assign st.cnt_full    = (count >= CW'(MAX_NODES));
  assign st.cnt_eq_deg  = (count == CW'(deg));
  assign st.used_ge_deg = (used >= deg);
  assign st.open_zero   = (rd_open == '0);
  assign st.open_one    = (rd_open == OPEN_W'(1));
  assign st.i_eq_cnt    = (idx_i == count);
  assign st.rot_zero    = (rot == '0);
  assign st.mod_done    = (bitc == '0);
  assign st.out_last    = (edge_n == '0) || ((ENW'(out_idx) + ENW'(1)) == edge_n);

  assign edge_valid = (edge_n != '0);
  assign new_end    = IDX_W'(cur_node);
  assign old_end    = (edge_n != '0) ? edge_buf[out_idx] : '0;
  assign status     = status_r;
  assign run_last   = st.out_last;
endmodule

>>> design/spiral_sequence_to_edges.sv
// Top level of the spiral sequence to edges block.
// Depends on sse_pkg, sse_if, sse_ram, sse_ctrl and sse_datapath.
//
// Usage:
//   items   : sink channel, one spiral node per transaction (degree,
//             jump_shift, first_node, final_node).
//   results : source channel, one transaction per edge made by the node,
//             or a single edgeless transaction; run_last marks the last one.
//   Every result of a node carries that node's status; the first error is
//   latched until the next node with first_node set.
//   One node is processed at a time. Start, error and held-error nodes
//   skip the ring walk; other nodes read the ring once per edge and per
//   ring entry examined. A middle node first runs the shift modulo
//   (bit-serial restoring remainder) and the ring rotation, each rotation
//   step a read and a write on the single ring RAM port pair. Then one
//   result transaction per cycle while the receiver takes them.
//   A stalled receiver holds the current result and blocks new nodes.
//   Reset (rst, synchronous) clears ring pointers, counters and the error
//   latch; the ring RAM itself is not cleared.
module spiral_sequence_to_edges #(
  parameter int MAX_NODES  = sse_pkg::MAX_NODES_DEF,
  parameter int MAX_DEGREE = sse_pkg::MAX_DEGREE_DEF
) (
  input logic         clk,
  input logic         rst,
  sse_item_if.sink    items,
  sse_edge_if.source  results
);
  import sse_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sse_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .degree    (items.degree),
    .jump_shift(items.jump_shift),
    .first_node(items.first_node),
    .final_node(items.final_node),
    .edge_valid(results.edge_valid),
    .new_end   (results.new_end),
    .old_end   (results.old_end),
    .status    (results.status),
    .run_last  (results.run_last)
  );
endmodule
